>>> rtl/fatc_pkg.sv
// Shared types and constants of the FAT cluster chain table.
package fatc_pkg;

  localparam logic [2:0] OP_READ   = 3'd0;
  localparam logic [2:0] OP_WRITE  = 3'd1;
  localparam logic [2:0] OP_ALLOC  = 3'd2;
  localparam logic [2:0] OP_CHAIN  = 3'd3;
  localparam logic [2:0] OP_FREE   = 3'd4;
  localparam logic [2:0] OP_COUNT  = 3'd5;

  localparam logic [27:0] LINK_FREE = 28'h0000000;
  localparam logic [27:0] EOC_MIN   = 28'hFFFFFF8;
  localparam logic [27:0] EOC_MARK  = 28'hFFFFFFF;

  typedef struct packed {
    logic [2:0]  op;
    logic        in_store;
    logic [27:0] cluster;
    logic [27:0] value;
  } fatc_cmd_t;

endpackage

>>> rtl/fat_cluster_chain_table_unit.sv
// Top level of the FAT cluster chain table.
// The block keeps a FAT32 allocation table in a local memory and serves one
// request per input. Requests arrive on the s_axis channel, results leave on
// m_axis, one result per request, in order. The user must write the cluster
// count on the cfg port only while the block is idle; the block itself does
// not enforce it. A two-entry queue parts the front end, which takes
// requests, from the back end, which runs them one at a time against the
// table memory, which has one read and one write port. A read passes
// through the read and evaluate states before its result; a write adds a
// write-back state. An allocate scans entries one by one from the hint, a
// chain allocation takes free entries and links each to the one before it
// in a second write pass, and a walk follows the chain cluster by cluster,
// writing each one back as free for a free.
// After reset the back end clears all TABLE_DEPTH entries of the table, one
// entry per cycle; requests queue meanwhile but are not served.
// When m_axis stalls, the result holds and the queue absorbs up to two more
// requests before s_axis_tready drops.
module fat_cluster_chain_table_unit
  import fatc_pkg::*;
#(
  parameter int TABLE_DEPTH = 4096
) (
  input  logic        clk,
  input  logic        rst,
  input  logic        cfg_we,
  input  logic [11:0] cfg_wdata,
  input  logic        s_axis_tvalid,
  output logic        s_axis_tready,
  // Fields from bit 0: operation[2:0], cluster[30:3], value[58:31].
  input  logic [63:0] s_axis_tdata,
  output logic        m_axis_tvalid,
  input  logic        m_axis_tready,
  // Fields from bit 0: ok[0], result_value[28:1].
  output logic [31:0] m_axis_tdata
);

  logic [11:0] num_clusters;
  fatc_cmd_t   cmd;
  logic        cmd_valid, cmd_ready, ok;
  logic [27:0] result_value;

  always_ff @(posedge clk) begin
    if (rst) num_clusters <= 12'd4094;
    else if (cfg_we) num_clusters <= cfg_wdata;
  end

  fatc_front #(.TABLE_DEPTH(TABLE_DEPTH)) u_front (
    .clk, .rst,
    .in_valid(s_axis_tvalid), .in_ready(s_axis_tready),
    .op(s_axis_tdata[2:0]), .cluster(s_axis_tdata[30:3]), .value(s_axis_tdata[58:31]),
    .cmd_valid, .cmd_ready, .cmd
  );

  fatc_back #(.TABLE_DEPTH(TABLE_DEPTH)) u_back (
    .clk, .rst, .num_clusters,
    .cmd_valid, .cmd_ready, .cmd,
    .out_valid(m_axis_tvalid), .out_ready(m_axis_tready),
    .ok, .result_value
  );

  assign m_axis_tdata = {3'd0, result_value, ok};

endmodule

>>> rtl/fatc_front.sv
// Front end: takes requests, checks store range and queues decoded commands.
module fatc_front
  import fatc_pkg::*;
#(
  parameter int TABLE_DEPTH = 4096
) (
  input  logic      clk,
  input  logic      rst,
  input  logic      in_valid,
  output logic      in_ready,
  input  logic [2:0]  op,
  input  logic [27:0] cluster,
  input  logic [27:0] value,
  output logic      cmd_valid,
  input  logic      cmd_ready,
  output fatc_cmd_t cmd
);

  fatc_cmd_t q [2];
  logic      wr_ptr, rd_ptr;
  logic [1:0] count;
  logic push, pop;

  assign in_ready  = (count != 2'd2);
  assign cmd_valid = (count != 2'd0);
  assign cmd       = q[rd_ptr];
  assign push      = in_valid && in_ready;
  assign pop       = cmd_valid && cmd_ready;

  always_ff @(posedge clk) begin
    if (push) begin
      q[wr_ptr].op       <= op;
      q[wr_ptr].in_store <= ({4'd0, cluster} < 32'(TABLE_DEPTH));
      q[wr_ptr].cluster  <= cluster;
      q[wr_ptr].value    <= value;
    end
    if (rst) begin
      wr_ptr <= 1'b0;
      rd_ptr <= 1'b0;
      count  <= 2'd0;
    end else begin
      if (push) wr_ptr <= ~wr_ptr;
      if (pop)  rd_ptr <= ~rd_ptr;
      count <= count + {1'b0, push} - {1'b0, pop};
    end
  end

endmodule

>>> rtl/fatc_back.sv
// Back end: table memory, clearing pass and the operation sequencer.
module fatc_back
  import fatc_pkg::*;
#(
  parameter int TABLE_DEPTH = 4096
) (
  input  logic        clk,
  input  logic        rst,
  input  logic [11:0] num_clusters,
  input  logic        cmd_valid,
  output logic        cmd_ready,
  input  fatc_cmd_t   cmd,
  output logic        out_valid,
  input  logic        out_ready,
  output logic        ok,
  output logic [27:0] result_value
);

  localparam int AW = $clog2(TABLE_DEPTH);

  typedef enum logic [2:0] {
    S_CLEAR, S_IDLE, S_RD, S_EVAL, S_WR, S_DONE
  } state_t;

  state_t state;
  logic [31:0] mem [TABLE_DEPTH];
  logic [31:0] rdata;
  logic        mem_we;
  logic [AW-1:0] mem_waddr, raddr;
  logic [31:0] mem_wdata;

  fatc_cmd_t   c;
  logic [AW-1:0] cur, prev;
  logic [12:0] hint;
  logic [27:0] remain, first;
  logic [12:0] steps;
  logic        have_prev;
  logic        link_prev;
  logic [AW-1:0] clr;
  logic [12:0] lim;
  logic [27:0] lnk;
  logic [13:0] lim_raw;

  assign lim_raw = {2'b0, num_clusters} + 14'd2;
  assign lim = (32'(lim_raw) > TABLE_DEPTH) ? 13'(TABLE_DEPTH) : lim_raw[12:0];
  assign lnk = rdata[27:0];

  function automatic logic valid_cl(input logic [27:0] x, input logic [12:0] l);
    valid_cl = (x >= 28'd2) && (x < {15'd0, l});
  endfunction

  always_ff @(posedge clk) begin
    if (mem_we) mem[mem_waddr] <= mem_wdata;
    rdata <= mem[raddr];
  end

  assign cmd_ready = (state == S_IDLE);

  always_comb begin
    mem_we = 1'b0;
    mem_waddr = cur;
    mem_wdata = {rdata[31:28], EOC_MARK};
    raddr = cur;
    if (state == S_CLEAR) begin
      mem_we = 1'b1;
      mem_waddr = clr;
      mem_wdata = 32'd0;
    end else if (state == S_WR) begin
      mem_we = 1'b1;
      mem_waddr = link_prev ? prev : cur;
      // Fetch the previous cluster so that the link pass keeps its top bits.
      if (have_prev && !link_prev) raddr = prev;
      unique case (c.op)
        OP_WRITE: mem_wdata = {rdata[31:28], c.value};
        OP_FREE:  mem_wdata = {rdata[31:28], LINK_FREE};
        default:  mem_wdata = link_prev ? {rdata[31:28], 28'(cur)}
                                        : {rdata[31:28], EOC_MARK};
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_CLEAR;
      clr <= '0;
      hint <= 13'd2;
      out_valid <= 1'b0;
    end else begin
      unique case (state)
        S_CLEAR: begin
          clr <= clr + 1'b1;
          if (clr == AW'(TABLE_DEPTH - 1)) state <= S_IDLE;
        end
        S_IDLE: begin
          if (cmd_valid) begin
            c <= cmd;
            ok <= 1'b0;
            result_value <= '0;
            have_prev <= 1'b0;
            link_prev <= 1'b0;
            remain <= cmd.value;
            first <= '0;
            steps <= '0;
            cur <= cmd.cluster[AW-1:0];
            state <= S_DONE;
            unique case (cmd.op)
              OP_READ, OP_WRITE: if (cmd.in_store) state <= S_RD;
              OP_ALLOC: begin
                cur <= hint[AW-1:0];
                if (hint < lim) state <= S_RD;
              end
              OP_CHAIN: begin
                cur <= hint[AW-1:0];
                if (cmd.value == 28'd0) ok <= 1'b1;
                else if (hint < lim) state <= S_RD;
              end
              OP_FREE, OP_COUNT: if (valid_cl(cmd.cluster, lim)) state <= S_RD;
              default: state <= S_DONE;
            endcase
          end
        end
        S_RD: state <= S_EVAL;
        S_EVAL: begin
          unique case (c.op)
            OP_READ: begin ok <= 1'b1; result_value <= lnk; state <= S_DONE; end
            OP_WRITE: begin ok <= 1'b1; result_value <= c.value; state <= S_WR; end
            OP_ALLOC, OP_CHAIN: begin
              if (lnk == LINK_FREE) begin
                hint <= 13'(cur) + 13'd1;
                state <= S_WR;
              end else if (13'(cur) + 13'd1 < lim) begin
                cur <= cur + 1'b1;
                state <= S_RD;
              end else begin
                state <= S_DONE;
                if (c.op == OP_CHAIN) result_value <= first;
              end
            end
            default: begin
              if (steps >= {1'b0, num_clusters}) begin
                state <= S_DONE;
                // A free entry where the step limit stopped the walk drops
                // the last cluster from the count.
                if (c.op == OP_COUNT)
                  result_value <= (lnk == LINK_FREE) ? 28'(steps - 13'd1) : 28'(steps);
              end else if (lnk == LINK_FREE) begin
                state <= S_DONE;
                if (c.op == OP_COUNT) result_value <= 28'(steps);
              end else begin
                steps <= steps + 13'd1;
                if (c.op == OP_COUNT) result_value <= 28'(steps + 13'd1);
                if (lnk >= EOC_MIN) ok <= 1'b1;
                if (c.op == OP_FREE) state <= S_WR;
                else if (lnk >= EOC_MIN || !valid_cl(lnk, lim)) state <= S_DONE;
                else begin cur <= lnk[AW-1:0]; state <= S_RD; end
              end
            end
          endcase
        end
        S_WR: begin
          state <= S_DONE;
          unique case (c.op)
            OP_FREE: begin
              result_value <= '0;
              if (lnk < EOC_MIN && valid_cl(lnk, lim)) begin
                cur <= lnk[AW-1:0];
                state <= S_RD;
              end
            end
            OP_ALLOC: begin ok <= 1'b1; result_value <= 28'(cur); end
            OP_CHAIN: begin
              if (!link_prev && have_prev) begin
                // Link the previous cluster to the new one on a second pass.
                link_prev <= 1'b1;
                state <= S_WR;
              end else begin
                link_prev <= 1'b0;
                if (!have_prev) first <= 28'(cur);
                have_prev <= 1'b1;
                prev <= cur;
                remain <= remain - 28'd1;
                if (remain == 28'd1) begin
                  ok <= 1'b1;
                  result_value <= have_prev ? first : 28'(cur);
                end else if (hint < lim) begin
                  cur <= hint[AW-1:0];
                  state <= S_RD;
                end else begin
                  result_value <= have_prev ? first : 28'(cur);
                end
              end
            end
            default: ;
          endcase
        end
        S_DONE: begin
          if (!out_valid) begin
            out_valid <= 1'b1;
          end else if (out_ready) begin
            out_valid <= 1'b0;
            state <= S_IDLE;
          end
        end
        default: state <= S_IDLE;
      endcase
    end
  end

endmodule
